### hw/rtl/pid_controller_antiwindup_core_assert.svh
// Assertion macros used by the checker file.
`ifndef PID_CONTROLLER_ANTIWINDUP_CORE_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_CORE_ASSERT_SVH

// Antecedent holds, then the consequent holds in the same cycle.
`define PIDAW_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pid core check failed");

// Antecedent holds, then the consequent holds in the next cycle.
`define PIDAW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pid core check failed");

`endif

### hw/rtl/pidaw_pkg.sv
package pidaw_pkg;

	localparam int DATA_W  = 16;
	localparam int ERR_W   = DATA_W + 1;
	localparam int GAIN_W  = 24;
	localparam int INTEG_W = 32;
	localparam int INC_W   = 29;
	localparam int PROD_W  = 60;
	localparam int SUM_W   = 52;
	localparam int CNT_W   = 5;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_GAIN_P     = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I     = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D     = 3'd2;
	localparam logic [IDX_W-1:0] REG_STEP_TIME  = 3'd3;
	localparam logic [IDX_W-1:0] REG_INV_STEP   = 3'd4;
	localparam logic [IDX_W-1:0] REG_UNWIND     = 3'd5;
	localparam logic [IDX_W-1:0] REG_OUT_MIN    = 3'd6;
	localparam logic [IDX_W-1:0] REG_OUT_MAX    = 3'd7;

	localparam logic signed [15:0] UNWIND_CLEAR = -16'sd4096;

endpackage

### hw/rtl/pid_controller_antiwindup_core.sv
// PID controller step with a saturating Q16.16 integral and anti-windup. Each item
// carries a command bit, a Q8.8 setpoint and a Q8.8 measurement; exactly one result
// (a Q8.8 drive value clamped to out_min/out_max plus a clamp flag) comes back per
// item. A command of one clears the integral and the stored error and returns zero.
// All products are formed by a single shift-add multiplier that consumes one bit of
// its multiplier operand per cycle. A control item's result is loaded into the
// output register after the increment, proportional, integral and both derivative
// multiplies, plus the anti-windup scaling multiply when that runs.
// A reset-command item skips the multiplies and goes straight to the output state.
// The input reopens in the cycle the result is loaded, and the next item may enter
// while the previous result still waits in the output register. A result that finds
// the output register still occupied holds the sequencer until that register frees up.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and must
// only be changed while no item is in progress.
module pid_controller_antiwindup_core
	import pidaw_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     command,
	input  logic signed [DATA_W-1:0] target,
	input  logic signed [DATA_W-1:0] measured,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] drive,
	output logic                     clamped,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [GAIN_W-1:0]        cfg_data
);

	// Sequencer states. Each multiply state loads the shared multiplier (all but S_INC
	// and S_P consuming the previous product), then steps it one bit per cycle.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INC  = 4'd1;
	localparam logic [3:0] S_UF   = 4'd2;
	localparam logic [3:0] S_UFX  = 4'd3;
	localparam logic [3:0] S_INT  = 4'd4;
	localparam logic [3:0] S_P    = 4'd5;
	localparam logic [3:0] S_I    = 4'd6;
	localparam logic [3:0] S_DV   = 4'd7;
	localparam logic [3:0] S_D    = 4'd8;
	localparam logic [3:0] S_SUM  = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	// Configuration registers.
	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [15:0]              step_time_q, inv_step_q;
	logic signed [15:0]       unwind_q, out_min_q, out_max_q;

	// Controller state and sequencer.
	logic [3:0]                state_q;
	logic                      run_q;
	logic                      cmd_q;
	logic signed [ERR_W-1:0]   err_q, last_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [INC_W-1:0]   inc_q;
	logic signed [SUM_W-1:0]   total_q;

	// Shared serial multiplier: the multiplicand shifts left, the multiplier
	// shifts right, and the accumulator adds the multiplicand when the low bit
	// is set. For a signed multiplier the sign bit carries negative weight.
	logic signed [PROD_W-1:0] mc_q, acc_q, acc_nx;
	logic [GAIN_W-1:0]        mp_q;
	logic                     mp_sgn_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     mul_sub;

	logic                      out_valid_q, clamped_q, out_free, out_load;
	logic signed [DATA_W-1:0]  drive_q;

	logic signed [24:0]        inc_raw;
	logic                      windup;
	logic signed [33:0]        integ_sum;
	logic signed [17:0]        err_diff;
	logic signed [35:0]        raw, omax_ext, omin_ext;

	assign mul_sub = mp_q[0] && mp_sgn_q && (cnt_q == '0);
	assign acc_nx  = mp_q[0] ? (mul_sub ? acc_q - mc_q : acc_q + mc_q) : acc_q;

	// The increment is error times dt, shifted down by eight.
	assign inc_raw = acc_q[32:8];

	// Anti-windup applies when error and integral are nonzero with opposite signs.
	assign windup = (err_q > 0 && integ_q < 0) || (err_q < 0 && integ_q > 0);

	assign integ_sum = {{2{integ_q[INTEG_W-1]}}, integ_q} + {{5{inc_q[INC_W-1]}}, inc_q};
	assign err_diff  = {err_q[ERR_W-1], err_q} - {last_q[ERR_W-1], last_q};

	assign raw      = total_q[SUM_W-1:16];
	assign omax_ext = {{20{out_max_q[15]}}, out_max_q};
	assign omin_ext = {{20{out_min_q[15]}}, out_min_q};

	// The output register is free when empty or when its item leaves this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_OUT) && !run_q && out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clamped   = clamped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			step_time_q <= 16'd655;
			inv_step_q  <= 16'd25600;
			unwind_q    <= 16'sd4096;
			out_min_q   <= -16'sd32768;
			out_max_q   <= 16'sd32767;
			state_q     <= S_IDLE;
			run_q       <= 1'b0;
			cmd_q       <= 1'b0;
			err_q       <= '0;
			last_q      <= '0;
			integ_q     <= '0;
			inc_q       <= '0;
			total_q     <= '0;
			mc_q        <= '0;
			acc_q       <= '0;
			mp_q        <= '0;
			mp_sgn_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			clamped_q   <= 1'b0;
			drive_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GAIN_P:    gain_p_q    <= cfg_data;
					REG_GAIN_I:    gain_i_q    <= cfg_data;
					REG_GAIN_D:    gain_d_q    <= cfg_data;
					REG_STEP_TIME: step_time_q <= cfg_data[15:0];
					REG_INV_STEP:  inv_step_q  <= cfg_data[15:0];
					REG_UNWIND:    unwind_q    <= cfg_data[15:0];
					REG_OUT_MIN:   out_min_q   <= cfg_data[15:0];
					REG_OUT_MAX:   out_max_q   <= cfg_data[15:0];
					default: ;
				endcase
			end

			// A new result takes the register; otherwise a departing one empties it.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (run_q) begin
				acc_q <= acc_nx;
				mc_q  <= mc_q <<< 1;
				mp_q  <= mp_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					unique case (state_q)
						S_INC:   state_q <= S_UF;
						S_UF:    state_q <= S_UFX;
						S_P:     state_q <= S_I;
						S_I:     state_q <= S_DV;
						S_DV:    state_q <= S_D;
						S_D:     state_q <= S_SUM;
						default: state_q <= S_IDLE;
					endcase
				end
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (in_valid) begin
							err_q   <= {target[DATA_W-1], target}
								- {measured[DATA_W-1], measured};
							cmd_q   <= command;
							state_q <= command ? S_OUT : S_INC;
						end
					end
					S_INC: begin
						mc_q     <= {{(PROD_W-ERR_W){err_q[ERR_W-1]}}, err_q};
						mp_q     <= {8'd0, step_time_q};
						mp_sgn_q <= 1'b0;
						cnt_q    <= 5'd15;
						acc_q    <= '0;
						run_q    <= 1'b1;
					end
					S_UF: begin
						if (!windup) begin
							inc_q   <= {{4{inc_raw[24]}}, inc_raw};
							state_q <= S_INT;
						end else if (unwind_q == UNWIND_CLEAR) begin
							integ_q <= '0;
							inc_q   <= '0;
							state_q <= S_INT;
						end else begin
							mc_q     <= {{35{inc_raw[24]}}, inc_raw};
							mp_q     <= {{8{unwind_q[15]}}, unwind_q};
							mp_sgn_q <= 1'b1;
							cnt_q    <= 5'd15;
							acc_q    <= '0;
							run_q    <= 1'b1;
						end
					end
					S_UFX: begin
						inc_q   <= acc_q[40:12];
						state_q <= S_INT;
					end
					S_INT: begin
						// Saturate the updated integral to its signed range.
						if (integ_sum[33:31] == 3'b000 || integ_sum[33:31] == 3'b111) begin
							integ_q <= integ_sum[INTEG_W-1:0];
						end else if (integ_sum[33]) begin
							integ_q <= {1'b1, {(INTEG_W-1){1'b0}}};
						end else begin
							integ_q <= {1'b0, {(INTEG_W-1){1'b1}}};
						end
						state_q <= S_P;
					end
					S_P: begin
						mc_q     <= {{(PROD_W-ERR_W){err_q[ERR_W-1]}}, err_q};
						mp_q     <= gain_p_q;
						mp_sgn_q <= 1'b1;
						cnt_q    <= 5'd23;
						acc_q    <= '0;
						run_q    <= 1'b1;
					end
					S_I: begin
						total_q  <= acc_q[SUM_W-1:0];
						mc_q     <= {{(PROD_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
						mp_q     <= gain_i_q;
						mp_sgn_q <= 1'b1;
						cnt_q    <= 5'd23;
						acc_q    <= '0;
						run_q    <= 1'b1;
					end
					S_DV: begin
						total_q  <= total_q + acc_q[PROD_W-1:8];
						mc_q     <= {{42{err_diff[17]}}, err_diff};
						mp_q     <= {8'd0, inv_step_q};
						mp_sgn_q <= 1'b0;
						cnt_q    <= 5'd15;
						acc_q    <= '0;
						run_q    <= 1'b1;
					end
					S_D: begin
						mc_q     <= {{26{acc_q[33]}}, acc_q[33:0]};
						mp_q     <= gain_d_q;
						mp_sgn_q <= 1'b1;
						cnt_q    <= 5'd23;
						acc_q    <= '0;
						run_q    <= 1'b1;
					end
					S_SUM: begin
						total_q <= total_q + acc_q[PROD_W-1:8];
						state_q <= S_OUT;
					end
					S_OUT: begin
						if (out_free) begin
							if (cmd_q) begin
								drive_q   <= '0;
								clamped_q <= 1'b0;
								integ_q   <= '0;
								last_q    <= '0;
							end else begin
								// When the limits cross, a value above out_max and below out_min takes out_max.
								if (raw > omax_ext) begin
									drive_q   <= out_max_q;
									clamped_q <= 1'b1;
								end else if (raw < omin_ext) begin
									drive_q   <= out_min_q;
									clamped_q <= 1'b1;
								end else begin
									drive_q   <= raw[DATA_W-1:0];
									clamped_q <= 1'b0;
								end
								last_q <= err_q;
							end
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule

### hw/rtl/pidaw_checker.sv
`include "pid_controller_antiwindup_core_assert.svh"

module pidaw_checker
	import pidaw_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [DATA_W-1:0] drive,
	input logic                     clamped
);

	// A stalled result keeps its value.
	`PIDAW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(drive) && $stable(clamped))

	// An accepted item keeps the input side busy in the following cycle.
	`PIDAW_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// A fresh result appears together with the input side opening again.
	`PIDAW_ASSERT_SAME(a_ready_with_result, $rose(out_valid), !in_stall)

endmodule

bind pid_controller_antiwindup_core pidaw_checker u_pidaw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.drive     (drive),
	.clamped   (clamped)
);
